FILE: sv/jls_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jls_pkg
// Shared types and constants for the Jacobi linear solver.
// ---------------------------------------------------------------------------
package jls_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_SOLVE   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    localparam logic [1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [1:0] CFG_MAX_ITER  = 2'd1;
    localparam logic [1:0] CFG_SIZE      = 2'd2;

    typedef struct packed {
        logic        start;
        logic        signed [63:0] num;
        logic        signed [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic signed [63:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: sv/jls_stream_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jls_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ---------------------------------------------------------------------------
interface jls_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/jacobi_linear_solver.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jacobi_linear_solver
// Loads A and b, then runs Jacobi sweeps from a zero guess on a solve
// transaction and emits one solution element per unknown.
// ---------------------------------------------------------------------------
// channel  dir  payload
// in       in   op[41:40] row[39:36] col[35:32] value[31:0]
// out      out  index[54:51] value[50:19] iterations[18:3] conv[2] sing[1] last[0]
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// Loads are accepted only while idle. A solve first runs the singular check
// on each diagonal entry, then runs sweeps paced by one shared multiplier
// and a serial divider, and finally outputs one element per unknown.
// Synchronous active-low reset; A and b are not cleared.
// Results wait in the output register while o_out.ready is low.
// ---------------------------------------------------------------------------
module jacobi_linear_solver #(
    parameter int MAX_SIZE    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data,
    jls_stream_if.sink       i_in,
    jls_stream_if.source     o_out
);
    import jls_pkg::*;

    localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int EW  = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (EW - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam int AD  = 2 * IW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHK   = 10'b0000000010,
        S_CHKW  = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_ACC   = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_DIVW  = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [30:0] r_tol;
    logic [15:0] r_maxit;
    logic [4:0]  r_size;

    logic signed [31:0] r_amem [MAX_SIZE*MAX_SIZE];
    logic signed [31:0] r_bmem [MAX_SIZE];
    logic signed [31:0] r_xc   [MAX_SIZE];
    logic signed [31:0] r_xp   [MAX_SIZE];
    logic signed [31:0] r_ard;
    logic signed [31:0] r_brd;
    logic signed [31:0] r_xrd;
    logic signed [31:0] r_diag;

    logic [IW-1:0] r_i, r_j;
    logic [IW:0]   r_n;
    logic [15:0]   r_limit, r_sweep;
    logic          r_phase;     // 0 update, 1 residual
    logic          r_sing, r_conv;
    logic signed [63:0] r_acc, r_prod, r_worst;
    logic          r_ovalid;
    logic [54:0]   r_odata;
    logic [IW-1:0] r_oi;

    t_div_req n_div_req;
    t_div_rsp n_div_rsp;

    logic [1:0]  n_op;
    logic [3:0]  n_row, n_col;
    logic signed [31:0] n_val;
    logic        n_in_acc;
    logic        n_out_free;
    logic signed [63:0] n_mul, n_err;
    logic [63:0] n_pm;
    logic        n_ineg;
    logic [IW-1:0] n_last_i;

    assign n_op     = i_in.data[41:40];
    assign n_row    = i_in.data[39:36];
    assign n_col    = i_in.data[35:32];
    assign n_val    = $signed(i_in.data[31:0]);
    assign n_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign n_in_acc = i_in.valid && i_in.ready;
    assign n_last_i = IW'(r_n - 1'b1);

    jls_divider #(.VW(EW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_div_req),
        .o_rsp  (n_div_rsp)
    );

    always_comb begin
        logic [63:0] ma, mb;
        ma     = r_ard[31] ? 64'(-64'(r_ard)) : 64'(r_ard);
        mb     = r_xrd[31] ? 64'(-64'(r_xrd)) : 64'(r_xrd);
        n_pm   = ma[32:0] * mb[32:0];
        n_ineg = r_ard[31] ^ r_xrd[31];
        n_mul  = n_ineg ? -$signed((n_pm + 64'h8000) >> FRAC_BITS)
                        :  $signed((n_pm + 64'h8000) >> FRAC_BITS);
        n_err  = r_acc[63] ? -r_acc : r_acc;
        n_div_req.start = (r_state == S_DIV);
        n_div_req.num   = r_acc;
        n_div_req.den   = 64'(r_diag);
    end

    function automatic logic signed [31:0] sat32(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > VMAX) begin
            w = VMAX;
        end else if (w < VMIN) begin
            w = VMIN;
        end
        return w[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_in_acc && n_op == OP_WRITE_A && 32'(n_row) < MAX_SIZE
            && 32'(n_col) < MAX_SIZE) begin
            r_amem[{IW'(n_row), IW'(n_col)}] <= sat32(n_val);
        end
        if (n_in_acc && n_op == OP_WRITE_B && 32'(n_row) < MAX_SIZE) begin
            r_bmem[IW'(n_row)] <= sat32(n_val);
        end
        r_ard <= r_amem[AD'({r_i, r_j})];
        r_diag <= r_amem[AD'({r_i, r_i})];
        r_brd <= r_bmem[r_i];
        r_xrd <= r_phase ? r_xc[r_j] : r_xp[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tol    <= 31'd655;
            r_maxit  <= 16'd1000;
            r_size   <= 5'd16;
            r_ovalid <= 1'b0;
            r_sweep  <= '0;
            r_conv   <= 1'b0;
            r_sing   <= 1'b0;
            for (int k = 0; k < MAX_SIZE; k++) begin
                r_xc[k] <= '0;
                r_xp[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOLERANCE: r_tol   <= i_cfg_data;
                    CFG_MAX_ITER:  r_maxit <= i_cfg_data[15:0];
                    CFG_SIZE:      r_size  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_in_acc && n_op == OP_SOLVE) begin
                        if (r_size == 5'd0) begin
                            r_n <= (IW+1)'(1);
                        end else if (32'(r_size) > MAX_SIZE) begin
                            r_n <= (IW+1)'(MAX_SIZE);
                        end else begin
                            r_n <= (IW+1)'(r_size);
                        end
                        r_limit <= (r_maxit == 16'd0) ? 16'd1 : r_maxit;
                        for (int k = 0; k < MAX_SIZE; k++) begin
                            r_xc[k] <= '0;
                            r_xp[k] <= '0;
                        end
                        r_sweep <= '0;
                        r_conv  <= 1'b0;
                        r_sing  <= 1'b0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= S_CHKW;
                end
                S_CHKW: begin
                    if (r_diag == 32'sd0) begin
                        r_sing <= 1'b1;
                    end
                    if (r_i == n_last_i) begin
                        r_i <= '0;
                        if (r_diag == 32'sd0 || r_sing) begin
                            r_oi    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_sweep <= 16'd1;
                            r_worst <= '0;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CHK;
                    end
                end
                S_RD: begin
                    // rd data for (i,j) lands next cycle
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_j == '0) begin
                        r_acc <= 64'(r_brd);
                    end
                    r_prod  <= (!r_phase && r_j == r_i) ? 64'sd0 : n_mul;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc - r_prod;
                    if (r_j == n_last_i) begin
                        r_j     <= '0;
                        r_state <= r_phase ? S_NEXT : S_DIV;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (n_div_rsp.done) begin
                        r_xc[r_i] <= n_div_rsp.quo[31:0];
                        r_state   <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_phase && n_err > r_worst) begin
                        r_worst <= n_err;
                    end
                    if (r_i != n_last_i) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RD;
                    end else if (!r_phase) begin
                        r_i     <= '0;
                        r_phase <= 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_i     <= '0;
                        r_phase <= 1'b0;
                        for (int k = 0; k < MAX_SIZE; k++) begin
                            r_xp[k] <= r_xc[k];
                        end
                        if ((((n_err > r_worst) ? n_err : r_worst) > VMAX ? VMAX
                             : ((n_err > r_worst) ? n_err : r_worst)) <= 64'(r_tol)) begin
                            r_conv  <= 1'b1;
                            r_oi    <= '0;
                            r_state <= S_OUT;
                        end else if (r_sweep == r_limit) begin
                            r_oi    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_sweep <= r_sweep + 16'd1;
                            r_worst <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'(r_oi), r_xc[r_oi],
                                     r_sing ? 16'd0 : r_sweep,
                                     r_conv, r_sing, r_oi == n_last_i};
                        if (r_oi == n_last_i) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oi <= r_oi + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    property p_busy_not_ready;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !i_in.ready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

    property p_sing_no_sweep;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_OUT && r_sing) |-> (r_sweep == 16'd0 && !r_conv);
    endproperty
    a_sing_no_sweep: assert property (p_sing_no_sweep) else $error("sweep on singular");

    property p_sweep_limit;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != S_IDLE && r_state != S_CHK && r_state != S_CHKW)
            |-> r_sweep <= r_limit;
    endproperty
    a_sweep_limit: assert property (p_sweep_limit) else $error("sweep over limit");

    property p_div_only_div;
        @(posedge i_clk) disable iff (!i_rst_n)
            n_div_rsp.done |-> r_state == S_DIVW;
    endproperty
    a_div_only_div: assert property (p_div_only_div) else $error("stray divide");

endmodule
`default_nettype wire

FILE: sv/jls_divider.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jls_divider
// Restoring divider, one quotient bit per cycle: Q16.16 quotient truncated
// toward zero and saturated to the value range.
// ---------------------------------------------------------------------------
module jls_divider #(
    parameter int VW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jls_pkg::t_div_req i_req,
    output jls_pkg::t_div_rsp  o_rsp
);
    import jls_pkg::*;

    localparam int QW = 80;
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

    logic [QW-1:0]  r_num;
    logic [63:0]    r_den;
    logic [64:0]    r_rem;
    logic [QW-1:0]  r_quo;
    logic [6:0]     r_cnt;
    logic           r_busy;
    logic           r_done;
    logic           r_neg;

    logic [63:0] n_mag_num;
    logic [63:0] n_mag_den;
    logic [64:0] n_trial;
    logic [64:0] n_shift;
    logic signed [63:0] n_res;
    logic [63:0] n_full;

    always_comb begin
        n_mag_num = i_req.num[63] ? 64'(-i_req.num) : i_req.num;
        n_mag_den = i_req.den[63] ? 64'(-i_req.den) : i_req.den;
        n_shift   = {r_rem[63:0], r_num[QW-1]};
        n_trial   = n_shift - {1'b0, r_den};
        // r_quo holds floor(|n|*2^16/|d|) which equals the truncated quotient
        n_full    = (r_quo > (QW'(1) << 56)) ? (64'd1 << 56) : r_quo[63:0];
        n_res     = r_neg ? -$signed(n_full) : $signed(n_full);
        if (n_res > VMAX) begin
            n_res = VMAX;
        end else if (n_res < VMIN) begin
            n_res = VMIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // widen numerator by FRAC_BITS
                r_num  <= QW'(n_mag_num) << FRAC_BITS;
                r_den  <= n_mag_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_neg  <= i_req.num[63] ^ i_req.den[63];
                r_cnt  <= 7'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!n_trial[64]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = n_res;

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("div done w/o busy");

    property p_cnt_idle;
        @(posedge i_clk) disable iff (!i_rst_n) !r_busy |-> r_cnt == 7'd0;
    endproperty
    a_cnt_idle: assert property (p_cnt_idle) else $error("div count nonzero idle");

    property p_no_restart;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !r_done;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("div busy and done");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for jacobi_linear_solver. It loads coefficient and
// right-hand side entries and issues solves with small systems, under random
// sender bursts and receiver stalls. A local fixed-point Jacobi predictor
// produces the expected solution elements, and every output transaction is
// checked field by field in order.
// ---------------------------------------------------------------------------
module tb;
    import jls_pkg::*;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic [15:0]        iterations;
        logic               converged;
        logic               singular;
        logic               last;
    } t_solution;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;

    jls_stream_if #(.W(42)) in_if ();
    jls_stream_if #(.W(55)) out_if ();

    jacobi_linear_solver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    longint      mat_a [256];
    longint      vec_b [16];
    logic [30:0] tol_q;
    logic [15:0] iter_limit_q;
    logic [4:0]  size_q;

    t_solution   solution_fifo [$];
    int          mismatches;
    int          burst_left;
    int          stall_left;
    int          cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic        neg;
        logic [63:0] p;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        p = mag64(a) * mag64(b);
        r = (p + 64'd32768) >> 16;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        logic        neg;
        logic [63:0] un, ud, q, r, full;
        longint      s;
        neg = (num < 0) != (den < 0);
        un = mag64(num);
        ud = mag64(den);
        q = un / ud;
        r = un % ud;
        if (q > (64'd1 << 40)) full = 64'd1 << 56;
        else full = (q << 16) + ((r << 16) / ud);
        s = longint'(full);
        return sat32(neg ? -s : s);
    endfunction

    task automatic predict_solve();
        longint    x_new [16];
        longint    x_old [16];
        longint    acc, worst;
        int        n, limit, sweeps;
        logic      sing, conv;
        t_solution sol;
        n = (size_q == 0) ? 1 : (size_q > 16 ? 16 : int'(size_q));
        limit = (iter_limit_q == 0) ? 1 : int'(iter_limit_q);
        sing = 1'b0;
        conv = 1'b0;
        sweeps = 0;
        for (int i = 0; i < 16; i++) begin
            x_new[i] = 0;
            x_old[i] = 0;
        end
        for (int i = 0; i < n; i++)
            if (mat_a[i*16+i] == 0) sing = 1'b1;
        if (!sing) begin
            for (int k = 1; k <= limit; k++) begin
                worst = 0;
                for (int i = 0; i < n; i++) begin
                    acc = vec_b[i];
                    for (int j = 0; j < n; j++)
                        if (j != i) acc -= fx_mul(mat_a[i*16+j], x_old[j]);
                    x_new[i] = fx_div(acc, mat_a[i*16+i]);
                end
                for (int i = 0; i < n; i++) begin
                    acc = vec_b[i];
                    for (int j = 0; j < n; j++) acc -= fx_mul(mat_a[i*16+j], x_new[j]);
                    if (acc < 0) acc = -acc;
                    if (acc > worst) worst = acc;
                end
                if (worst > 64'sd2147483647) worst = 64'sd2147483647;
                sweeps = k;
                x_old = x_new;
                if (worst <= longint'(tol_q)) begin
                    conv = 1'b1;
                    break;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            sol.index      = 4'(i);
            sol.value      = x_new[i][31:0];
            sol.iterations = 16'(sweeps);
            sol.converged  = conv;
            sol.singular   = sing;
            sol.last       = (i == n - 1);
            solution_fifo.push_back(sol);
        end
    endtask

    // Send one transaction; the caller is at a rising edge.
    task automatic send_item(t_op op, logic [3:0] row, logic [3:0] col,
                             logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.data  <= {op, row, col, value};
        do @(posedge i_clk); while (!in_if.ready);
        case (op)
            OP_WRITE_A: mat_a[row*16+col] = longint'(signed'(value));
            OP_WRITE_B: vec_b[row] = longint'(signed'(value));
            OP_SOLVE:   predict_solve();
            default: ;
        endcase
    endtask

    // Hold off until every expected result has drained.
    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (solution_fifo.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TOLERANCE: tol_q = data;
            CFG_MAX_ITER:  iter_limit_q = data[15:0];
            CFG_SIZE:      size_q = data[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [30:0] tol, logic [15:0] iters, logic [4:0] size);
        drain();
        cfg_write(CFG_TOLERANCE, tol);
        cfg_write(CFG_MAX_ITER, 31'(iters));
        cfg_write(CFG_SIZE, 31'(size));
    endtask

    function automatic logic [31:0] small_value();
        return 32'($signed($urandom_range(0, 65536)) - 32768);
    endfunction

    task automatic load_dominant(int n);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++)
                send_item(OP_WRITE_A, 4'(i), 4'(j), i == j ?
                          ($urandom_range(0, 1) ? 32'h0010_0000 : 32'hFFF0_0000)
                          + small_value() : small_value());
            send_item(OP_WRITE_B, 4'(i), 4'd0, $urandom);
        end
    endtask

    task automatic test_load_all();
        load_dominant(6);
    endtask

    task automatic test_size_extremes();
        configure(31'd655, 16'd2, 5'd6);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
        for (int i = 6; i < 16; i++)
            send_item(OP_WRITE_A, 4'(i), 4'(i), i == 15 ? 32'd0 : 32'h0001_0000);
        configure(31'd655, 16'd1, 5'd31);
        send_item(OP_SOLVE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        configure(31'd655, 16'd10, 5'd1);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
        configure(31'd655, 16'd10, 5'd0);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_iteration_extremes();
        configure(31'd0, 16'd0, 5'd3);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
        configure(31'h7FFF_FFFF, 16'hFFFF, 5'd3);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
        configure(31'd0, 16'd4, 5'd3);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_value_extremes();
        configure(31'd655, 16'd3, 5'd2);
        send_item(OP_WRITE_A, 4'd0, 4'd1, 32'h7FFF_FFFF);
        send_item(OP_WRITE_A, 4'd1, 4'd0, 32'h8000_0000);
        send_item(OP_WRITE_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(OP_WRITE_B, 4'd1, 4'd0, 32'h8000_0000);
        send_item(OP_WRITE_A, 4'd0, 4'd0, 32'h0000_0001);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_singular();
        send_item(OP_WRITE_A, 4'd1, 4'd1, 32'd0);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
        send_item(OP_WRITE_A, 4'd1, 4'd1, 32'h0001_0000);
        send_item(OP_NONE, 4'd5, 4'd5, 32'h1234_5678);
        send_item(OP_SOLVE, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_random();
        int n;
        int kind;
        for (int s = 0; s < 5; s++) begin
            n = $urandom_range(1, 4);
            if ($urandom_range(0, 2) != 0) begin
                kind = $urandom_range(0, 3);
                configure(kind == 0 ? 31'd0 : kind == 1 ? 31'h7FFF_FFFF :
                          kind == 2 ? 31'd655 : 31'($urandom_range(0, 200000)),
                          16'($urandom_range(0, 25)), 5'(n));
            end
            n = (size_q == 0) ? 1 : (size_q > 16 ? 16 : int'(size_q));
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                load_dominant(n);
            end else begin
                for (int k = 0; k < n + 2; k++)
                    send_item($urandom_range(0, 1) ? OP_WRITE_A : OP_WRITE_B,
                              4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
                              kind == 7 ? 32'd0 : $urandom);
            end
            if ($urandom_range(0, 4) == 0)
                send_item(OP_NONE, 4'($urandom), 4'($urandom), $urandom);
            if ($urandom_range(0, 3) == 0)
                send_item(OP_WRITE_A, 4'($urandom), 4'($urandom), $urandom);
            send_item(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom);
        end
    endtask

    always @(posedge i_clk) begin
        t_solution got;
        t_solution want;
        cycle_cnt <= cycle_cnt + 1;
        if (out_if.valid && out_if.ready) begin
            got.index      = out_if.data[54:51];
            got.value      = out_if.data[50:19];
            got.iterations = out_if.data[18:3];
            got.converged  = out_if.data[2];
            got.singular   = out_if.data[1];
            got.last       = out_if.data[0];
            if (solution_fifo.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: index %0d value %h", $time,
                         got.index, got.value);
            end else begin
                want = solution_fifo.pop_front();
                if (got != want) begin
                    mismatches++;
                    $display("%0t expected idx %0d val %h it %0d cv %b sg %b lst %b", $time,
                             want.index, want.value, want.iterations, want.converged,
                             want.singular, want.last);
                    $display("%0t actual   idx %0d val %h it %0d cv %b sg %b lst %b", $time,
                             got.index, got.value, got.iterations, got.converged,
                             got.singular, got.last);
                end
            end
        end
        if (cycle_cnt[11]) begin
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 6);
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_TOLERANCE;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        tol_q        = 31'd655;
        iter_limit_q = 16'd1000;
        size_q       = 5'd16;
        mismatches   = 0;
        burst_left   = 0;
        stall_left   = 0;
        cycle_cnt    = 0;
        for (int i = 0; i < 256; i++) mat_a[i] = 0;
        for (int i = 0; i < 16; i++) vec_b[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_all();
        test_size_extremes();
        test_iteration_extremes();
        test_singular();
        test_value_extremes();
        configure(31'd655, 16'd8, 5'd3);
        load_dominant(3);
        test_random();
        drain();
        mismatches += solution_fifo.size();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
